// ----- rtl/sync_type_length_deframer_unit_defines.svh -----
// Assertion macros used by the deframer top-level RTL file.
// No dependencies; included by files that carry concurrent checks.
`ifndef SYNC_TYPE_LENGTH_DEFRAMER_UNIT_DEFINES_SVH
`define SYNC_TYPE_LENGTH_DEFRAMER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Check a property at every clock edge outside reset.
`define SLTD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("deframer check failed");
// Check that a condition implies another in the same cycle.
`define SLTD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer implication failed");
// Check that a condition implies another in the next cycle.
`define SLTD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer next-cycle check failed");
`else
`define SLTD_ASSERT(label, clk, rst_n, prop)
`define SLTD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SLTD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/sltd_pkg.sv -----
// Types and constants of the sync/type/length deframer.
// No dependencies; used by sltd_obuf and the top level.
package sltd_pkg;

    typedef enum logic [2:0] {
        PH_HUNT1   = 3'd0,
        PH_HUNT2   = 3'd1,
        PH_TYPE    = 3'd2,
        PH_LEN_LO  = 3'd3,
        PH_LEN_HI  = 3'd4,
        PH_PAYLOAD = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        OUT_PAYLOAD  = 2'd0,
        OUT_EMPTY    = 2'd1,
        OUT_OVERSIZE = 2'd2
    } outcome_t;

    localparam logic [1:0] CFG_SYNC_FIRST  = 2'd0;
    localparam logic [1:0] CFG_SYNC_SECOND = 2'd1;
    localparam logic [1:0] CFG_MAX_LENGTH  = 2'd2;

    localparam logic [7:0]  SYNC_FIRST_RESET  = 8'hAA;
    localparam logic [7:0]  SYNC_SECOND_RESET = 8'h55;
    localparam logic [15:0] MAX_LENGTH_RESET  = 16'd8192;

    typedef struct packed {
        outcome_t    outcome;
        logic [7:0]  packet_type;
        logic [7:0]  payload_byte;
        logic [15:0] byte_index;
        logic        last;
        logic [15:0] length;
    } result_t;

endpackage

// ----- rtl/sltd_obuf.sv -----
// Output register stage of the deframer result channel.
// Depends on sltd_pkg for the result beat type.
module sltd_obuf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  sltd_pkg::result_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output sltd_pkg::result_t out_data
);

    logic              valid_reg;
    sltd_pkg::result_t data_reg;

    // take a new beat whenever the held one leaves or none is held
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // hold control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    // load payload on a new beat
    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= in_data;
        end
    end

endmodule

// ----- rtl/sync_type_length_deframer_unit.sv -----
// Sync/type/length frame parser over a received byte stream.
// Depends on sltd_pkg, sltd_obuf and the assertion macro header.
//
// Takes one byte per beat and emits one result per payload byte, plus one
// result for an empty or oversize frame; header bytes give no result. A byte
// is accepted every clock cycle unless input stalls; its result is held in the output register
// from the cycle after acceptance. Input stalls only while that single output register
// holds a beat the sink has not taken. Configuration writes take effect at the
// next clock edge and belong while no frame is in progress.
`include "sync_type_length_deframer_unit_defines.svh"
module sync_type_length_deframer_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_outcome,
    output logic [7:0]  m_packet_type,
    output logic [7:0]  m_payload_byte,
    output logic [15:0] m_byte_index,
    output logic        m_last,
    output logic [15:0] m_length
);

    logic [7:0]  sync_first_reg;
    logic [7:0]  sync_second_reg;
    logic [15:0] max_length_reg;

    sltd_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  type_reg, type_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] count_reg, count_next;

    logic              s_fire;
    logic              res_valid;
    sltd_pkg::result_t res_data;
    sltd_pkg::result_t out_data;
    logic [15:0]       full_len;
    logic [15:0]       idx_inc;
    logic              pay_last;

    assign s_fire   = s_valid && s_ready;
    assign full_len = {s_data_byte, len_reg[7:0]};
    assign idx_inc  = count_reg + 16'd1;
    assign pay_last = (idx_inc == len_reg);

    // write configuration registers; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_first_reg  <= sltd_pkg::SYNC_FIRST_RESET;
            sync_second_reg <= sltd_pkg::SYNC_SECOND_RESET;
            max_length_reg  <= sltd_pkg::MAX_LENGTH_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                sltd_pkg::CFG_SYNC_FIRST:  sync_first_reg  <= cfg_wr_data[7:0];
                sltd_pkg::CFG_SYNC_SECOND: sync_second_reg <= cfg_wr_data[7:0];
                sltd_pkg::CFG_MAX_LENGTH:  max_length_reg  <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // next phase
    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            sltd_pkg::PH_HUNT2:
                phase_next = (s_data_byte == sync_second_reg) ? sltd_pkg::PH_TYPE
                                                              : sltd_pkg::PH_HUNT1;
            sltd_pkg::PH_TYPE:   phase_next = sltd_pkg::PH_LEN_LO;
            sltd_pkg::PH_LEN_LO: phase_next = sltd_pkg::PH_LEN_HI;
            sltd_pkg::PH_LEN_HI:
                phase_next = (full_len == 16'd0 || full_len > max_length_reg)
                           ? sltd_pkg::PH_HUNT1 : sltd_pkg::PH_PAYLOAD;
            sltd_pkg::PH_PAYLOAD:
                phase_next = pay_last ? sltd_pkg::PH_HUNT1 : sltd_pkg::PH_PAYLOAD;
            default:
                phase_next = (s_data_byte == sync_first_reg) ? sltd_pkg::PH_HUNT2
                                                             : sltd_pkg::PH_HUNT1;
        endcase
    end

    // frame fields and result beat
    always_comb begin
        type_next             = type_reg;
        len_next              = len_reg;
        count_next            = count_reg;
        res_valid             = 1'b0;
        res_data.outcome      = sltd_pkg::OUT_PAYLOAD;
        res_data.packet_type  = type_reg;
        res_data.payload_byte = 8'd0;
        res_data.byte_index   = 16'd0;
        res_data.last         = 1'b1;
        res_data.length       = len_reg;
        unique case (phase_reg)
            sltd_pkg::PH_TYPE:   type_next = s_data_byte;
            sltd_pkg::PH_LEN_LO: len_next  = {8'd0, s_data_byte};
            sltd_pkg::PH_LEN_HI: begin
                len_next        = full_len;
                count_next      = 16'd0;
                res_data.length = full_len;
                if (full_len == 16'd0) begin
                    res_valid        = 1'b1;
                    res_data.outcome = sltd_pkg::OUT_EMPTY;
                end else if (full_len > max_length_reg) begin
                    res_valid        = 1'b1;
                    res_data.outcome = sltd_pkg::OUT_OVERSIZE;
                end
            end
            sltd_pkg::PH_PAYLOAD: begin
                res_valid             = 1'b1;
                res_data.payload_byte = s_data_byte;
                res_data.byte_index   = count_reg;
                res_data.last         = pay_last;
                count_next            = idx_inc;
            end
            default: ;
        endcase
    end

    // advance parser state on an accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= sltd_pkg::PH_HUNT1;
            type_reg  <= 8'd0;
            len_reg   <= 16'd0;
            count_reg <= 16'd0;
        end else if (s_fire) begin
            phase_reg <= phase_next;
            type_reg  <= type_next;
            len_reg   <= len_next;
            count_reg <= count_next;
        end
    end

    sltd_obuf u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid && res_valid),
        .in_ready  (s_ready),
        .in_data   (res_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_data)
    );

    assign m_outcome      = out_data.outcome;
    assign m_packet_type  = out_data.packet_type;
    assign m_payload_byte = out_data.payload_byte;
    assign m_byte_index   = out_data.byte_index;
    assign m_last         = out_data.last;
    assign m_length       = out_data.length;

    `SLTD_ASSERT_IMPL(a_ctrl_result_shape, aclk, aresetn, m_valid && m_outcome != sltd_pkg::OUT_PAYLOAD, m_last && m_payload_byte == 8'd0 && m_byte_index == 16'd0)
    `SLTD_ASSERT_IMPL(a_payload_in_range, aclk, aresetn, phase_reg == sltd_pkg::PH_PAYLOAD, len_reg != 16'd0 && count_reg < len_reg)
    `SLTD_ASSERT_NEXT(a_payload_gives_beat, aclk, aresetn, s_fire && phase_reg == sltd_pkg::PH_PAYLOAD, m_valid)
    `SLTD_ASSERT(a_stall_only_when_full, aclk, aresetn, s_ready || m_valid)

endmodule
